>>> rtl/swg_pkg.sv
// ---------------------------------------------------------------------------
// swg_pkg
// Shared types, constants and the elaboration-time sigmoid breakpoint builder
// ---------------------------------------------------------------------------
package swg_pkg;

  localparam int SIGMOID_SEGMENTS_DEF = 64;

  localparam int GATE_W = 16;
  localparam int SIG_W  = 16;

  localparam logic [63:0] ONE_Q28 = 64'd1 << 28;

  // element pair with its interpolated sigmoid, passed between the two halves
  typedef struct packed {
    logic signed [GATE_W-1:0] gate;
    logic signed [GATE_W-1:0] linear;
    logic [SIG_W-1:0]         sig;
  } swg_sig_t;

  // shift-subtract long division, only evaluated at elaboration
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32768 * sigmoid(-8 + 16k/s)) in unsigned q1.15
  function automatic logic [SIG_W-1:0] sig_point(input int k, input int s);
    logic [63:0] k64;
    logic [63:0] s64;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] er;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] v;
    k64  = 64'(k);
    s64  = 64'(s);
    neg  = (k64 << 4) < (s64 << 3);
    mag  = neg ? (s64 << 3) - (k64 << 4) : (k64 << 4) - (s64 << 3);
    a    = udiv(mag << 28, s64);
    r    = a >> 3;
    term = ONE_Q28;
    er   = ONE_Q28;
    for (int i = 1; i <= 16; i++) begin
      term = udiv((term * r) >> 28, 64'(i));
      er   = er + term;
    end
    e = udiv(64'd1 << 56, er);
    for (int i = 0; i < 3; i++) begin
      e = (e * e) >> 28;
    end
    d = ONE_Q28 + e;
    n = neg ? e : ONE_Q28;
    v = udiv((n << 15) + (d >> 1), d);
    return v[SIG_W-1:0];
  endfunction

endpackage

>>> rtl/swiglu_activation_unit.sv
// ---------------------------------------------------------------------------
// swiglu_activation_unit
// Streaming swiglu activation: gate * sigmoid(gate) * linear in q4.12
// ---------------------------------------------------------------------------
// Takes one (gate, linear) pair per cycle while the output is not stalled and
// returns one rounded, saturated q4.12 product per pair, in order. The seven
// register stages are: segment index, sigmoid table read, slope times
// fraction, interpolation add, gate times sigmoid, times linear, and round
// with saturation. The sigmoid table holds SIGMOID_SEGMENTS rows of constant
// breakpoint and step, built at elaboration, and is read once per item. Each
// stage stalls only while it holds an item that the next cannot take, so
// bubbles close up under backpressure and a full pipeline holds seven items.
module swiglu_activation_unit #(
  parameter int SIGMOID_SEGMENTS = swg_pkg::SIGMOID_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // gate_value [15:0], linear_value [31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // product [15:0]
  output logic        m_tuser    // saturated [0]
);
  import swg_pkg::*;

  logic     sig_valid;
  logic     sig_ready;
  swg_sig_t sig_data;
  logic signed [GATE_W-1:0] product;

  swg_sigmoid #(
    .SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)
  ) u_sigmoid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_gate   ($signed(s_tdata[15:0])),
    .in_linear ($signed(s_tdata[31:16])),
    .out_valid (sig_valid),
    .out_ready (sig_ready),
    .out_data  (sig_data)
  );

  swg_mult u_mult (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (sig_valid),
    .in_ready      (sig_ready),
    .in_data       (sig_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_product   (product),
    .out_saturated (m_tuser)
  );

  assign m_tdata = product;

endmodule

>>> rtl/swg_sigmoid.sv
// ---------------------------------------------------------------------------
// swg_sigmoid
// Four-stage piecewise-linear sigmoid of the gate value
// ---------------------------------------------------------------------------
module swg_sigmoid #(
  parameter int SIGMOID_SEGMENTS = swg_pkg::SIGMOID_SEGMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swg_pkg::GATE_W-1:0]    in_gate,
  input  logic signed [swg_pkg::GATE_W-1:0]    in_linear,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output swg_pkg::swg_sig_t                    out_data
);
  import swg_pkg::*;

  localparam int KW = $clog2(SIGMOID_SEGMENTS);
  localparam int MW = GATE_W + KW;

  // breakpoint value and step to the next breakpoint, one row per segment
  logic [SIG_W-1:0]  lut_v [SIGMOID_SEGMENTS];
  logic signed [SIG_W:0] lut_d [SIGMOID_SEGMENTS];

  for (genvar j = 0; j < SIGMOID_SEGMENTS; j++) begin : g_lut
    localparam logic [SIG_W-1:0] V0 = sig_point(j, SIGMOID_SEGMENTS);
    localparam logic [SIG_W-1:0] V1 = sig_point(j + 1, SIGMOID_SEGMENTS);
    assign lut_v[j] = V0;
    assign lut_d[j] = (SIG_W+1)'(V1) - (SIG_W+1)'(V0);
  end

  logic [3:0] vld;
  logic [4:0] adv;

  assign adv[4] = out_ready;
  for (genvar i = 0; i < 4; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end
  assign in_ready  = adv[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  // stage 1: segment index and fraction
  logic [MW-1:0]            m_c;
  logic [KW-1:0]            idx1;
  logic [GATE_W-1:0]        frac1;
  logic signed [GATE_W-1:0] gate1, lin1;

  // offset binary of the gate spans the whole table
  assign m_c = MW'({~in_gate[GATE_W-1], in_gate[GATE_W-2:0]}) * MW'(SIGMOID_SEGMENTS);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      idx1  <= m_c[MW-1:GATE_W];
      frac1 <= m_c[GATE_W-1:0];
      gate1 <= in_gate;
      lin1  <= in_linear;
    end
  end

  // stage 2: table read
  logic [SIG_W-1:0]         v2;
  logic signed [SIG_W:0]    d2;
  logic [GATE_W-1:0]        frac2;
  logic signed [GATE_W-1:0] gate2, lin2;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      v2    <= lut_v[idx1];
      d2    <= lut_d[idx1];
      frac2 <= frac1;
      gate2 <= gate1;
      lin2  <= lin1;
    end
  end

  // stage 3: step times fraction
  logic signed [33:0]       prod_c;
  logic signed [33:0]       prod3;
  logic [SIG_W-1:0]         v3;
  logic signed [GATE_W-1:0] gate3, lin3;

  assign prod_c = d2 * $signed({1'b0, frac2});

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      prod3 <= prod_c;
      v3    <= v2;
      gate3 <= gate2;
      lin3  <= lin2;
    end
  end

  // stage 4: rounded correction added to the breakpoint
  logic signed [33:0] sum_c;

  assign sum_c = $signed({18'b0, v3}) + ((prod3 + 34'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      out_data.sig    <= sum_c[SIG_W-1:0];
      out_data.gate   <= gate3;
      out_data.linear <= lin3;
    end
  end

endmodule

>>> rtl/swg_mult.sv
// ---------------------------------------------------------------------------
// swg_mult
// Three-stage swish and linear products with rounding and saturation
// ---------------------------------------------------------------------------
module swg_mult (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  swg_pkg::swg_sig_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [swg_pkg::GATE_W-1:0] out_product,
  output logic                              out_saturated
);
  import swg_pkg::*;

  localparam logic signed [48:0] Q_MAX  = 49'sd32767;
  localparam logic signed [48:0] Q_MIN  = -49'sd32768;
  localparam logic signed [48:0] RND    = 49'sd1 <<< 26;

  logic [2:0] vld;
  logic [3:0] adv;

  assign adv[3] = out_ready;
  for (genvar i = 0; i < 3; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end
  assign in_ready  = adv[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  // stage 1: swish in q6.27
  logic signed [32:0]       swish_c;
  logic signed [32:0]       swish1;
  logic signed [GATE_W-1:0] lin1;

  assign swish_c = in_data.gate * $signed({1'b0, in_data.sig});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      swish1 <= swish_c;
      lin1   <= in_data.linear;
    end
  end

  // stage 2: times linear, q.39
  logic signed [48:0] p_c;
  logic signed [48:0] p2;

  assign p_c = swish1 * lin1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p2 <= p_c;
    end
  end

  // stage 3: round half up and clip
  logic signed [48:0] q_c;

  assign q_c = (p2 + RND) >>> 27;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      if (q_c > Q_MAX) begin
        out_product   <= Q_MAX[GATE_W-1:0];
        out_saturated <= 1'b1;
      end else if (q_c < Q_MIN) begin
        out_product   <= Q_MIN[GATE_W-1:0];
        out_saturated <= 1'b1;
      end else begin
        out_product   <= q_c[GATE_W-1:0];
        out_saturated <= 1'b0;
      end
    end
  end

endmodule
